### sv/vmb_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and arithmetic helpers of the view matrix builder.
// Used by vmb_norm and view_matrix_builder_unit; depends on nothing.
package vmb_pkg;

   // Word format and internal unit-vector precision
   localparam int WORD_BITS  = 32;
   localparam int FRAC_BITS  = 16;
   localparam int UNIT_BITS  = 30;

   localparam int VEC_W      = UNIT_BITS + 2;        // signed unit component, holds +-1.0
   localparam int WIDE_W     = 2 * UNIT_BITS + 4;    // signed vector into a normalizer
   localparam int SUM_W      = 2 * UNIT_BITS + 2;    // sum of three squares
   localparam int LEN_W      = UNIT_BITS + 1;        // vector length
   localparam int NUM_W      = 2 * UNIT_BITS + 1;    // dividend of one unit component
   localparam int QUO_W      = UNIT_BITS + 1;        // quotient, up to 1.0
   localparam int ROOT_STEPS = SUM_W / 2;
   localparam int DIV_STEPS  = QUO_W;
   localparam int BL_W       = $clog2(WIDE_W + 1);
   localparam int PROD_W     = VEC_W + WORD_BITS;
   localparam int SAT_W      = PROD_W + 8;

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic signed [VEC_W-1:0]     vec_type;
   typedef logic signed [WIDE_W-1:0]    wide_type;
   typedef logic signed [SAT_W-1:0]     sat_type;
   typedef logic        [UNIT_BITS-1:0] umag_type;

   // Rounding constants
   localparam int      RND_K    = UNIT_BITS - FRAC_BITS;
   localparam sat_type RND_HALF = (RND_K == 0) ? sat_type'(0) : (sat_type'(1) <<< (RND_K - 1));
   localparam sat_type HALF_U   = sat_type'(1) <<< (UNIT_BITS - 1);

   // Bottom-right matrix entry, 1.0 saturated to the word
   localparam word_type ONE_ENTRY = (FRAC_BITS >= WORD_BITS - 1)
      ? word_type'((64'd1 << (WORD_BITS - 1)) - 64'd1)
      : word_type'(64'd1 << FRAC_BITS);

   // Row carried by a result word
   typedef enum logic [1:0] {
      ROW_SIDE = 2'd0,
      ROW_UP   = 2'd1,
      ROW_FWD  = 2'd2,
      ROW_LAST = 2'd3
   } row_type;

   // Side data that rides along a normalizer
   typedef struct packed {
      word_type [2:0] eye;
      vec_type  [2:0] vec;
      logic           deg;
   } side_type;

   // Bit length of a magnitude: index of the top set bit plus one
   function automatic logic [BL_W-1:0] bit_len(input logic [WIDE_W-1:0] m);
      logic [BL_W-1:0] r;
      r = '0;
      for (int i = 0; i < WIDE_W; i++) begin
         if (m[i]) r = BL_W'(i + 1);
      end
      return r;
   endfunction

   // Shift a magnitude so a bit length of bl lands on UNIT_BITS bits
   function automatic umag_type scale_mag(input logic [WIDE_W-1:0] m,
                                          input logic [BL_W-1:0]   bl);
      if (bl > BL_W'(UNIT_BITS)) begin
         return umag_type'(m >> (bl - BL_W'(UNIT_BITS)));
      end else begin
         return umag_type'(m << (BL_W'(UNIT_BITS) - bl));
      end
   endfunction

   // Clamp to the signed word range
   function automatic word_type sat_word(input sat_type v);
      sat_type hi;
      sat_type lo;
      hi = (sat_type'(1) <<< (WORD_BITS - 1)) - sat_type'(1);
      lo = -hi - sat_type'(1);
      if (v > hi) begin
         return hi[WORD_BITS-1:0];
      end else if (v < lo) begin
         return lo[WORD_BITS-1:0];
      end else begin
         return v[WORD_BITS-1:0];
      end
   endfunction

endpackage

### sv/vmb_norm.sv
`timescale 1ns / 1ps
// Pipelined vector normalizer: power-of-two scaling, sum of squares,
// digit-by-digit square root and restoring division. Depends on vmb_pkg.
module vmb_norm
   import vmb_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic     in_valid,
   input  wide_type in_vec [3],
   input  side_type in_side,
   output logic     out_valid,
   output vec_type  out_unit [3],
   output side_type out_side
);

   typedef struct packed {
      umag_type [2:0] sm;
      logic     [2:0] neg;
      logic           zero;
      side_type       side;
   } carry_type;

   // Magnitudes and signs
   logic              s1_v_ff;
   logic [WIDE_W-1:0] s1_mag_ff [3];
   logic [2:0]        s1_neg_ff;
   side_type          s1_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= in_valid;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            s1_mag_ff[i] <= in_vec[i][WIDE_W-1] ? WIDE_W'(-in_vec[i]) : WIDE_W'(in_vec[i]);
            s1_neg_ff[i] <= in_vec[i][WIDE_W-1];
         end
         s1_side_ff <= in_side;
      end
   end

   // Largest magnitude
   logic              s2_v_ff;
   logic [WIDE_W-1:0] s2_max_ff;
   logic [WIDE_W-1:0] s2_mag_ff [3];
   logic [2:0]        s2_neg_ff;
   side_type          s2_side_ff;
   logic [WIDE_W-1:0] max01;

   assign max01 = (s1_mag_ff[0] > s1_mag_ff[1]) ? s1_mag_ff[0] : s1_mag_ff[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (en) begin
         s2_v_ff <= s1_v_ff;
      end
      if (en) begin
         s2_max_ff  <= (max01 > s1_mag_ff[2]) ? max01 : s1_mag_ff[2];
         s2_mag_ff  <= s1_mag_ff;
         s2_neg_ff  <= s1_neg_ff;
         s2_side_ff <= s1_side_ff;
      end
   end

   // Bit length of the largest magnitude
   logic              s3_v_ff;
   logic [BL_W-1:0]   s3_bl_ff;
   logic              s3_zero_ff;
   logic [WIDE_W-1:0] s3_mag_ff [3];
   logic [2:0]        s3_neg_ff;
   side_type          s3_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (en) begin
         s3_v_ff <= s2_v_ff;
      end
      if (en) begin
         s3_bl_ff   <= bit_len(s2_max_ff);
         s3_zero_ff <= (s2_max_ff == '0);
         s3_mag_ff  <= s2_mag_ff;
         s3_neg_ff  <= s2_neg_ff;
         s3_side_ff <= s2_side_ff;
      end
   end

   // Scale to UNIT_BITS significant bits
   logic      s4_v_ff;
   carry_type s4_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else if (en) begin
         s4_v_ff <= s3_v_ff;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            s4_c_ff.sm[i] <= scale_mag(s3_mag_ff[i], s3_bl_ff);
         end
         s4_c_ff.neg  <= s3_neg_ff;
         s4_c_ff.zero <= s3_zero_ff;
         s4_c_ff.side <= s3_side_ff;
      end
   end

   // Squares
   logic                   s5_v_ff;
   logic [2*UNIT_BITS-1:0] s5_sq_ff [3];
   carry_type              s5_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_v_ff <= 1'b0;
      end else if (en) begin
         s5_v_ff <= s4_v_ff;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            s5_sq_ff[i] <= s4_c_ff.sm[i] * s4_c_ff.sm[i];
         end
         s5_c_ff <= s4_c_ff;
      end
   end

   // Square root, one result bit per stage; stage 0 holds the sum
   logic             rv_ff [ROOT_STEPS+1];
   logic [SUM_W-1:0] rx_ff [ROOT_STEPS+1];
   logic [SUM_W-1:0] rr_ff [ROOT_STEPS+1];
   carry_type        rc_ff [ROOT_STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff[0] <= 1'b0;
      end else if (en) begin
         rv_ff[0] <= s5_v_ff;
      end
      if (en) begin
         rx_ff[0] <= SUM_W'(s5_sq_ff[0]) + SUM_W'(s5_sq_ff[1]) + SUM_W'(s5_sq_ff[2]);
         rr_ff[0] <= '0;
         rc_ff[0] <= s5_c_ff;
      end
   end

   for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
      localparam logic [SUM_W:0] RBIT = (SUM_W+1)'(1) << (2 * (ROOT_STEPS - 1 - k));
      logic [SUM_W:0]   trial;
      logic [SUM_W-1:0] x_in;
      logic [SUM_W-1:0] r_in;

      // Try the next root bit, keep it if the remainder allows
      always_comb begin
         trial = {1'b0, rr_ff[k]} + RBIT;
         if ({1'b0, rx_ff[k]} >= trial) begin
            x_in = SUM_W'({1'b0, rx_ff[k]} - trial);
            r_in = SUM_W'({1'b0, rr_ff[k] >> 1} + RBIT);
         end else begin
            x_in = rx_ff[k];
            r_in = rr_ff[k] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            rv_ff[k+1] <= 1'b0;
         end else if (en) begin
            rv_ff[k+1] <= rv_ff[k];
         end
         if (en) begin
            rx_ff[k+1] <= x_in;
            rr_ff[k+1] <= r_in;
            rc_ff[k+1] <= rc_ff[k];
         end
      end
   end

   // Division, one quotient bit per stage; stage 0 forms the dividends
   logic             dv_ff   [DIV_STEPS+1];
   logic [LEN_W-1:0] drem_ff [DIV_STEPS+1][3];
   logic [QUO_W-1:0] dlow_ff [DIV_STEPS+1][3];
   logic [QUO_W-1:0] dquo_ff [DIV_STEPS+1][3];
   logic [LEN_W-1:0] dlen_ff [DIV_STEPS+1];
   carry_type        dc_ff   [DIV_STEPS+1];
   logic [LEN_W-1:0] root_len;
   logic [NUM_W-1:0] num [3];

   assign root_len = rr_ff[ROOT_STEPS][LEN_W-1:0];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num[i] = (NUM_W'(rc_ff[ROOT_STEPS].sm[i]) << UNIT_BITS) + NUM_W'(root_len >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (en) begin
         dv_ff[0] <= rv_ff[ROOT_STEPS];
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            drem_ff[0][i] <= LEN_W'(num[i] >> QUO_W);
            dlow_ff[0][i] <= num[i][QUO_W-1:0];
            dquo_ff[0][i] <= '0;
         end
         dlen_ff[0] <= root_len;
         dc_ff[0]   <= rc_ff[ROOT_STEPS];
      end
   end

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      logic [LEN_W:0]   trial [3];
      logic [LEN_W-1:0] rem_in [3];
      logic [2:0]       qbit;

      // Bring down the next dividend bit and subtract the length if it fits
      always_comb begin
         for (int i = 0; i < 3; i++) begin
            trial[i] = {drem_ff[j][i], dlow_ff[j][i][QUO_W-1-j]};
            if (trial[i] >= {1'b0, dlen_ff[j]}) begin
               rem_in[i] = LEN_W'(trial[i] - {1'b0, dlen_ff[j]});
               qbit[i]   = 1'b1;
            end else begin
               rem_in[i] = trial[i][LEN_W-1:0];
               qbit[i]   = 1'b0;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[j+1] <= 1'b0;
         end else if (en) begin
            dv_ff[j+1] <= dv_ff[j];
         end
         if (en) begin
            for (int i = 0; i < 3; i++) begin
               drem_ff[j+1][i] <= rem_in[i];
               dlow_ff[j+1][i] <= dlow_ff[j][i];
               dquo_ff[j+1][i] <= {dquo_ff[j][i][QUO_W-2:0], qbit[i]};
            end
            dlen_ff[j+1] <= dlen_ff[j];
            dc_ff[j+1]   <= dc_ff[j];
         end
      end
   end

   // Reapply signs, fold a zero vector into the degenerate flag
   logic     o_v_ff;
   vec_type  o_unit_ff [3];
   side_type o_side_ff;
   vec_type  quo [3];
   side_type side_fold;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         quo[i] = vec_type'(dquo_ff[DIV_STEPS][i]);
      end
      side_fold     = dc_ff[DIV_STEPS].side;
      side_fold.deg = dc_ff[DIV_STEPS].side.deg | dc_ff[DIV_STEPS].zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_v_ff <= 1'b0;
      end else if (en) begin
         o_v_ff <= dv_ff[DIV_STEPS];
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            o_unit_ff[i] <= dc_ff[DIV_STEPS].neg[i] ? -quo[i] : quo[i];
         end
         o_side_ff <= side_fold;
      end
   end

   assign out_valid = o_v_ff;
   assign out_unit  = o_unit_ff;
   assign out_side  = o_side_ff;

endmodule

### sv/view_matrix_builder_unit.sv
`timescale 1ns / 1ps
// Look-at view matrix builder, top level. The first row word of an item is
// presented from the output row buffer; rows 1 to 3 follow.
// Throughput is set by the four row words per item on the single result
// channel; the pipeline itself takes a word every cycle while it is not stalled.
// Reset: synchronous, active high; clears all valid bits and the row counter.
// Depends on vmb_pkg and vmb_norm.
module view_matrix_builder_unit
   import vmb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  word_type    req_eye_x,
   input  word_type    req_eye_y,
   input  word_type    req_eye_z,
   input  word_type    req_target_x,
   input  word_type    req_target_y,
   input  word_type    req_target_z,
   input  word_type    req_up_x,
   input  word_type    req_up_y,
   input  word_type    req_up_z,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_row_index,
   output word_type    rsp_entry0,
   output word_type    rsp_entry1,
   output word_type    rsp_entry2,
   output word_type    rsp_entry3,
   output logic        rsp_degenerate,
   output logic        rsp_last_row
);

   logic    en;
   logic    d6_v_ff;
   row_type cnt_ff;

   // Advance the whole pipe unless the output row buffer is still busy
   assign en        = !d6_v_ff || (!rsp_stall && (cnt_ff == ROW_LAST));
   assign req_stall = !en;

   // Input capture
   word_type req_eye [3];
   word_type req_tgt [3];
   word_type req_up  [3];

   assign req_eye = '{req_eye_x, req_eye_y, req_eye_z};
   assign req_tgt = '{req_target_x, req_target_y, req_target_z};
   assign req_up  = '{req_up_x, req_up_y, req_up_z};

   logic     t0_v_ff;
   word_type t0_eye_ff [3];
   word_type t0_tgt_ff [3];
   word_type t0_up_ff  [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         t0_v_ff <= 1'b0;
      end else if (en) begin
         t0_v_ff <= req_valid;
      end
      if (en) begin
         t0_eye_ff <= req_eye;
         t0_tgt_ff <= req_tgt;
         t0_up_ff  <= req_up;
      end
   end

   // Forward direction and up magnitudes
   logic                 t1_v_ff;
   wide_type             t1_dir_ff  [3];
   word_type             t1_eye_ff  [3];
   logic [WORD_BITS-1:0] t1_umag_ff [3];
   logic [2:0]           t1_uneg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_v_ff <= 1'b0;
      end else if (en) begin
         t1_v_ff <= t0_v_ff;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            t1_dir_ff[i]  <= wide_type'(t0_tgt_ff[i]) - wide_type'(t0_eye_ff[i]);
            t1_umag_ff[i] <= t0_up_ff[i][WORD_BITS-1] ? WORD_BITS'(-t0_up_ff[i])
                                                      : WORD_BITS'(t0_up_ff[i]);
            t1_uneg_ff[i] <= t0_up_ff[i][WORD_BITS-1];
         end
         t1_eye_ff <= t0_eye_ff;
      end
   end

   // Largest up magnitude
   logic                 t2_v_ff;
   logic [WORD_BITS-1:0] t2_umax_ff;
   wide_type             t2_dir_ff  [3];
   word_type             t2_eye_ff  [3];
   logic [WORD_BITS-1:0] t2_umag_ff [3];
   logic [2:0]           t2_uneg_ff;
   logic [WORD_BITS-1:0] umax01;

   assign umax01 = (t1_umag_ff[0] > t1_umag_ff[1]) ? t1_umag_ff[0] : t1_umag_ff[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         t2_v_ff <= 1'b0;
      end else if (en) begin
         t2_v_ff <= t1_v_ff;
      end
      if (en) begin
         t2_umax_ff <= (umax01 > t1_umag_ff[2]) ? umax01 : t1_umag_ff[2];
         t2_dir_ff  <= t1_dir_ff;
         t2_eye_ff  <= t1_eye_ff;
         t2_umag_ff <= t1_umag_ff;
         t2_uneg_ff <= t1_uneg_ff;
      end
   end

   // Bit length of the up vector
   logic                 t3_v_ff;
   logic [BL_W-1:0]      t3_ubl_ff;
   wide_type             t3_dir_ff  [3];
   word_type             t3_eye_ff  [3];
   logic [WORD_BITS-1:0] t3_umag_ff [3];
   logic [2:0]           t3_uneg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t3_v_ff <= 1'b0;
      end else if (en) begin
         t3_v_ff <= t2_v_ff;
      end
      if (en) begin
         t3_ubl_ff  <= bit_len(WIDE_W'(t2_umax_ff));
         t3_dir_ff  <= t2_dir_ff;
         t3_eye_ff  <= t2_eye_ff;
         t3_umag_ff <= t2_umag_ff;
         t3_uneg_ff <= t2_uneg_ff;
      end
   end

   // Scaled, signed up vector; a zero up vector stays zero
   logic     t4_v_ff;
   wide_type t4_dir_ff [3];
   side_type t4_side_ff;
   vec_type  up_scaled [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         up_scaled[i] = vec_type'(scale_mag(WIDE_W'(t3_umag_ff[i]), t3_ubl_ff));
         if (t3_uneg_ff[i]) up_scaled[i] = -up_scaled[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t4_v_ff <= 1'b0;
      end else if (en) begin
         t4_v_ff <= t3_v_ff;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            t4_side_ff.eye[i] <= t3_eye_ff[i];
            t4_side_ff.vec[i] <= up_scaled[i];
         end
         t4_side_ff.deg <= 1'b0;
         t4_dir_ff      <= t3_dir_ff;
      end
   end

   // Forward unit vector
   logic     n1_v;
   vec_type  n1_unit [3];
   side_type n1_side;

   vmb_norm u_norm_fwd (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (t4_v_ff),
      .in_vec    (t4_dir_ff),
      .in_side   (t4_side_ff),
      .out_valid (n1_v),
      .out_unit  (n1_unit),
      .out_side  (n1_side)
   );

   // Cross f x up: products, then differences
   logic     c1_v_ff;
   wide_type c1_p_ff [6];
   side_type c1_side_ff;
   side_type c1_side_in;

   always_comb begin
      c1_side_in = n1_side;
      for (int i = 0; i < 3; i++) begin
         c1_side_in.vec[i] = n1_unit[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_v_ff <= 1'b0;
      end else if (en) begin
         c1_v_ff <= n1_v;
      end
      if (en) begin
         c1_p_ff[0] <= n1_unit[1] * $signed(n1_side.vec[2]);
         c1_p_ff[1] <= n1_unit[2] * $signed(n1_side.vec[1]);
         c1_p_ff[2] <= n1_unit[2] * $signed(n1_side.vec[0]);
         c1_p_ff[3] <= n1_unit[0] * $signed(n1_side.vec[2]);
         c1_p_ff[4] <= n1_unit[0] * $signed(n1_side.vec[1]);
         c1_p_ff[5] <= n1_unit[1] * $signed(n1_side.vec[0]);
         c1_side_ff <= c1_side_in;
      end
   end

   logic     c2_v_ff;
   wide_type c2_c_ff [3];
   side_type c2_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c2_v_ff <= 1'b0;
      end else if (en) begin
         c2_v_ff <= c1_v_ff;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            c2_c_ff[i] <= c1_p_ff[2*i] - c1_p_ff[2*i+1];
         end
         c2_side_ff <= c1_side_ff;
      end
   end

   // Side unit vector
   logic     n2_v;
   vec_type  n2_unit [3];
   side_type n2_side;

   vmb_norm u_norm_side (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (c2_v_ff),
      .in_vec    (c2_c_ff),
      .in_side   (c2_side_ff),
      .out_valid (n2_v),
      .out_unit  (n2_unit),
      .out_side  (n2_side)
   );

   // Cross s x f for the up row
   logic     d1_v_ff;
   wide_type d1_p_ff [6];
   vec_type  d1_s_ff [3];
   side_type d1_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_v_ff <= 1'b0;
      end else if (en) begin
         d1_v_ff <= n2_v;
      end
      if (en) begin
         d1_p_ff[0] <= n2_unit[1] * $signed(n2_side.vec[2]);
         d1_p_ff[1] <= n2_unit[2] * $signed(n2_side.vec[1]);
         d1_p_ff[2] <= n2_unit[2] * $signed(n2_side.vec[0]);
         d1_p_ff[3] <= n2_unit[0] * $signed(n2_side.vec[2]);
         d1_p_ff[4] <= n2_unit[0] * $signed(n2_side.vec[1]);
         d1_p_ff[5] <= n2_unit[1] * $signed(n2_side.vec[0]);
         d1_s_ff    <= n2_unit;
         d1_side_ff <= n2_side;
      end
   end

   logic     d2_v_ff;
   wide_type d2_c_ff [3];
   vec_type  d2_s_ff [3];
   side_type d2_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d2_v_ff <= 1'b0;
      end else if (en) begin
         d2_v_ff <= d1_v_ff;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            d2_c_ff[i] <= d1_p_ff[2*i] - d1_p_ff[2*i+1];
         end
         d2_s_ff    <= d1_s_ff;
         d2_side_ff <= d1_side_ff;
      end
   end

   // Round the up row back to UNIT_BITS fraction bits
   logic     d3_v_ff;
   vec_type  d3_u_ff [3];
   vec_type  d3_s_ff [3];
   side_type d3_side_ff;
   sat_type  u_round [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         u_round[i] = (sat_type'(d2_c_ff[i]) + HALF_U) >>> UNIT_BITS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d3_v_ff <= 1'b0;
      end else if (en) begin
         d3_v_ff <= d2_v_ff;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            d3_u_ff[i] <= u_round[i][VEC_W-1:0];
         end
         d3_s_ff    <= d2_s_ff;
         d3_side_ff <= d2_side_ff;
      end
   end

   // Row entries and dot products with the eye
   logic                     d4_v_ff;
   logic signed [PROD_W-1:0] d4_prod_ff [3][3];
   word_type                 d4_ent_ff  [3][3];
   logic                     d4_deg_ff;
   vec_type                  rows [3][3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rows[0][i] = d3_s_ff[i];
         rows[1][i] = d3_u_ff[i];
         rows[2][i] = $signed(d3_side_ff.vec[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d4_v_ff <= 1'b0;
      end else if (en) begin
         d4_v_ff <= d3_v_ff;
      end
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
               d4_prod_ff[k][i] <= rows[k][i] * $signed(d3_side_ff.eye[i]);
               d4_ent_ff[k][i]  <= sat_word((sat_type'(rows[k][i]) + RND_HALF) >>> RND_K);
            end
         end
         d4_deg_ff <= d3_side_ff.deg;
      end
   end

   logic     d5_v_ff;
   sat_type  d5_dot_ff [3];
   word_type d5_ent_ff [3][3];
   logic     d5_deg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d5_v_ff <= 1'b0;
      end else if (en) begin
         d5_v_ff <= d4_v_ff;
      end
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            d5_dot_ff[k] <= sat_type'(d4_prod_ff[k][0]) + sat_type'(d4_prod_ff[k][1])
                          + sat_type'(d4_prod_ff[k][2]);
         end
         d5_ent_ff <= d4_ent_ff;
         d5_deg_ff <= d4_deg_ff;
      end
   end

   // Translation column; zero the rows of a degenerate item. Holds the output rows.
   word_type d6_ent_ff [3][4];
   logic     d6_deg_ff;
   sat_type  tr [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         tr[k] = -((d5_dot_ff[k] + HALF_U) >>> UNIT_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d6_v_ff <= 1'b0;
      end else if (en) begin
         d6_v_ff <= d5_v_ff;
      end
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
               d6_ent_ff[k][i] <= d5_deg_ff ? '0 : d5_ent_ff[k][i];
            end
            d6_ent_ff[k][3] <= d5_deg_ff ? '0 : sat_word(tr[k]);
         end
         d6_deg_ff <= d5_deg_ff;
      end
   end

   // Row counter: step on each taken word, wrap after the last row
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= ROW_SIDE;
      end else if (d6_v_ff && !rsp_stall) begin
         cnt_ff <= (cnt_ff == ROW_LAST) ? ROW_SIDE : row_type'(cnt_ff + 2'd1);
      end
   end

   // Select the row on the result port
   always_comb begin
      rsp_entry0 = '0;
      rsp_entry1 = '0;
      rsp_entry2 = '0;
      rsp_entry3 = '0;
      case (cnt_ff) inside
         ROW_SIDE, ROW_UP, ROW_FWD: begin
            rsp_entry0 = d6_ent_ff[cnt_ff[1:0]][0];
            rsp_entry1 = d6_ent_ff[cnt_ff[1:0]][1];
            rsp_entry2 = d6_ent_ff[cnt_ff[1:0]][2];
            rsp_entry3 = d6_ent_ff[cnt_ff[1:0]][3];
         end
         ROW_LAST: begin
            rsp_entry3 = ONE_ENTRY;
         end
         default: begin
            rsp_entry3 = '0;
         end
      endcase
   end

   assign rsp_valid      = d6_v_ff;
   assign rsp_row_index  = cnt_ff;
   assign rsp_degenerate = d6_deg_ff;
   assign rsp_last_row   = (cnt_ff == ROW_LAST);

`ifndef SYNTHESIS
   a_row_wrap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last_row |=> rsp_row_index == ROW_SIDE)
      else $error("row counter did not wrap after the last row");

   a_row_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_row |=>
         rsp_valid && rsp_row_index == 2'($past(rsp_row_index) + 2'd1))
      else $error("item left before all four rows were taken");

   a_pipe_hold: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(d5_v_ff) && $stable(n2_v) && $stable(n1_v))
      else $error("pipeline moved while stalled");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate && !rsp_last_row |->
         rsp_entry0 == '0 && rsp_entry1 == '0 && rsp_entry2 == '0 && rsp_entry3 == '0)
      else $error("degenerate row carries nonzero entries");
`endif

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// Testbench of view_matrix_builder_unit: look-at camera items go in, four
// matrix row words come out per item. Depends on vmb_pkg and the RTL only.
module tb;
   import vmb_pkg::*;

   typedef logic signed [127:0] big_type;
   typedef big_type vec3_type [3];

   // One row word as seen on the result channel
   typedef struct packed {
      logic [1:0] row;
      word_type   e0;
      word_type   e1;
      word_type   e2;
      word_type   e3;
      logic       deg;
      logic       last;
   } row_word_type;

   // One camera setup: eye, target, up
   typedef struct {
      word_type   eye [3];
      word_type   tgt [3];
      word_type   up  [3];
   } camera_type;

   // Directed stimulus row; typed rows carry rows 0..2 and the flag by hand
   typedef struct {
      camera_type cam;
      bit         typed;
      word_type   ent [3][4];
      bit         deg;
   } directed_type;

   localparam word_type WMAX = 32'sh7fffffff;
   localparam word_type WMIN = 32'sh80000000;
   localparam word_type ONE  = 32'sd65536;
   localparam int       LATENCY = 160;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   word_type   req_eye_x = '0, req_eye_y = '0, req_eye_z = '0;
   word_type   req_target_x = '0, req_target_y = '0, req_target_z = '0;
   word_type   req_up_x = '0, req_up_y = '0, req_up_z = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_row_index;
   word_type   rsp_entry0, rsp_entry1, rsp_entry2, rsp_entry3;
   logic       rsp_degenerate, rsp_last_row;

   row_word_type pending_rows [$];
   int         mismatches = 0;
   int         hold_left = 0;
   bit         calm = 0;

   view_matrix_builder_unit DUT (.*);

   always #10 clock = ~clock;

   // Arithmetic shift right with round half up
   function automatic big_type rnd_shift(big_type v, int k);
      if (k == 0) return v;
      return (v + (big_type'(1) <<< (k - 1))) >>> k;
   endfunction

   function automatic word_type sat32(big_type v);
      if (v > big_type'(WMAX)) return WMAX;
      if (v < big_type'(WMIN)) return WMIN;
      return v[31:0];
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Scale so the largest magnitude has 30 significant bits; 0 if all zero
   function automatic bit scale30(vec3_type v, output vec3_type o);
      big_type m [3];
      big_type mx;
      int   bl;
      mx = 0;
      bl = 0;
      for (int i = 0; i < 3; i++) o[i] = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = v[i] < 0 ? -v[i] : v[i];
         if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) return 0;
      for (int i = 0; i < 127; i++) if (mx[i]) bl = i + 1;
      for (int i = 0; i < 3; i++) begin
         m[i] = bl > UNIT_BITS ? m[i] >> (bl - UNIT_BITS) : m[i] << (UNIT_BITS - bl);
         o[i] = v[i] < 0 ? -m[i] : m[i];
      end
      return 1;
   endfunction

   function automatic bit unit_vec(vec3_type v, output vec3_type o);
      vec3_type    sc;
      logic [63:0] sum;
      big_type     len, m;
      if (!scale30(v, sc)) return 0;
      sum = 0;
      for (int i = 0; i < 3; i++) sum = sum + 64'(sc[i] * sc[i]);
      len = big_type'(int_sqrt(sum));
      for (int i = 0; i < 3; i++) begin
         m = sc[i] < 0 ? -sc[i] : sc[i];
         m = ((m << UNIT_BITS) + (len >> 1)) / len;
         o[i] = sc[i] < 0 ? -m : m;
      end
      return 1;
   endfunction

   function automatic void cross3(vec3_type a, vec3_type b, output vec3_type c);
      c[0] = a[1] * b[2] - a[2] * b[1];
      c[1] = a[2] * b[0] - a[0] * b[2];
      c[2] = a[0] * b[1] - a[1] * b[0];
   endfunction

   // Work out the four row words of one camera setup
   function automatic void predict_view_rows(camera_type c, output row_word_type r [4]);
      vec3_type eye, dir, upv, ups, f, s, u, x;
      bit    deg;
      word_type ent [4][4];
      big_type  d;
      for (int i = 0; i < 3; i++) begin
         eye[i] = big_type'(c.eye[i]);
         dir[i] = big_type'(c.tgt[i]) - eye[i];
         upv[i] = big_type'(c.up[i]);
         ups[i] = 0;
      end
      void'(scale30(upv, ups));
      deg = !unit_vec(dir, f);
      if (!deg) begin
         cross3(f, ups, x);
         deg = !unit_vec(x, s);
      end
      for (int k = 0; k < 4; k++) for (int i = 0; i < 4; i++) ent[k][i] = '0;
      if (!deg) begin
         cross3(s, f, x);
         for (int i = 0; i < 3; i++) u[i] = rnd_shift(x[i], UNIT_BITS);
         for (int k = 0; k < 3; k++) begin
            if (k == 0) x = s;
            else if (k == 1) x = u;
            else x = f;
            d = 0;
            for (int i = 0; i < 3; i++) begin
               ent[k][i] = sat32(rnd_shift(x[i], UNIT_BITS - FRAC_BITS));
               d = d + x[i] * eye[i];
            end
            ent[k][3] = sat32(-rnd_shift(d, UNIT_BITS));
         end
      end
      ent[3][3] = ONE_ENTRY;
      for (int k = 0; k < 4; k++)
         r[k] = '{row: 2'(k), e0: ent[k][0], e1: ent[k][1], e2: ent[k][2],
                  e3: ent[k][3], deg: deg, last: k == 3};
   endfunction

   // Offer one camera setup, optionally idle first, and log its rows on accept
   task automatic send_camera(camera_type c, bit typed, word_type ent [3][4], bit deg);
      row_word_type r [4];
      if (!calm && $urandom_range(99) < 22) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      {req_eye_x, req_eye_y, req_eye_z} <= {c.eye[0], c.eye[1], c.eye[2]};
      {req_target_x, req_target_y, req_target_z} <= {c.tgt[0], c.tgt[1], c.tgt[2]};
      {req_up_x, req_up_y, req_up_z} <= {c.up[0], c.up[1], c.up[2]};
      do @(posedge clock); while (req_stall);
      predict_view_rows(c, r);
      if (typed)
         for (int k = 0; k < 3; k++)
            r[k] = '{row: 2'(k), e0: ent[k][0], e1: ent[k][1], e2: ent[k][2],
                     e3: ent[k][3], deg: deg, last: 1'b0};
      if (typed && deg) r[3].deg = 1'b1;
      for (int k = 0; k < 4; k++) pending_rows.push_back(r[k]);
   endtask

   function automatic word_type rand_coord();
      int pick;
      pick = $urandom_range(99);
      if (pick < 45) return $urandom;
      if (pick < 85) return $signed($urandom_range(32'h1fffff)) - 32'sh100000;
      return $signed($urandom_range(32'h1ff)) - 32'sh100;
   endfunction

   function automatic camera_type rand_camera();
      camera_type c;
      int      pick;
      for (int i = 0; i < 3; i++) begin
         c.eye[i] = rand_coord();
         c.tgt[i] = rand_coord();
         c.up[i]  = rand_coord();
      end
      pick = $urandom_range(99);
      // broken setups: eye on target, zero up, up along the view direction
      if (pick < 4) c.tgt = c.eye;
      else if (pick < 7) c.up = '{0, 0, 0};
      else if (pick < 10) for (int i = 0; i < 3; i++) c.up[i] = c.tgt[i] - c.eye[i];
      return c;
   endfunction

   // Receiver: random stall, long hold-off on request, calm stretch
   initial begin
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left = hold_left - 1;
         end else begin
            rsp_stall <= !calm && $urandom_range(99) < 22;
         end
      end
   end

   // Compare each taken row word with the oldest expectation
   always @(posedge clock) begin
      row_word_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{row: rsp_row_index, e0: rsp_entry0, e1: rsp_entry1, e2: rsp_entry2,
                 e3: rsp_entry3, deg: rsp_degenerate, last: rsp_last_row};
         if (pending_rows.size() == 0) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10) $display("unexpected row word %p", got);
         end else begin
            want = pending_rows.pop_front();
            if (got !== want) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10) $display("row mismatch: expected %p got %p", want, got);
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      directed_type dir_tab [$];
      directed_type d;
      word_type  z [3][4];
      camera_type c;
      int        n;

      for (int k = 0; k < 3; k++) for (int i = 0; i < 4; i++) z[k][i] = '0;
      // looking down -z with +y up gives side +x, up +y and forward -z rows
      d.cam = '{eye: '{0, 0, 0}, tgt: '{0, 0, -ONE}, up: '{0, ONE, 0}};
      d.typed = 1; d.deg = 0; d.ent = z;
      d.ent[0][0] = ONE; d.ent[1][1] = ONE; d.ent[2][2] = -ONE;
      dir_tab.push_back(d);
      // target on eye, zero up, up along forward: degenerate, rows zeroed
      d.typed = 1; d.deg = 1; d.ent = z;
      d.cam = '{eye: '{0, 0, 0}, tgt: '{0, 0, 0}, up: '{0, ONE, 0}};
      dir_tab.push_back(d);
      d.cam = '{eye: '{WMAX, WMIN, WMAX}, tgt: '{WMAX, WMIN, WMAX}, up: '{WMIN, WMIN, WMIN}};
      dir_tab.push_back(d);
      d.cam = '{eye: '{1, 2, 3}, tgt: '{ONE, 5, -7}, up: '{0, 0, 0}};
      dir_tab.push_back(d);
      d.cam = '{eye: '{0, 0, 0}, tgt: '{0, ONE, 0}, up: '{0, 3, 0}};
      dir_tab.push_back(d);
      d.cam = '{eye: '{WMIN, 0, 0}, tgt: '{WMAX, 0, 0}, up: '{WMAX, 0, 0}};
      dir_tab.push_back(d);
      // extremes checked against the predictor
      d.typed = 0;
      d.cam = '{eye: '{WMIN, WMIN, WMIN}, tgt: '{WMAX, WMAX, WMAX}, up: '{0, WMAX, 0}};
      dir_tab.push_back(d);
      d.cam = '{eye: '{WMAX, WMAX, WMAX}, tgt: '{WMIN, WMIN, WMIN}, up: '{WMIN, 0, 0}};
      dir_tab.push_back(d);
      d.cam = '{eye: '{WMAX, WMIN, 0}, tgt: '{0, 0, WMAX}, up: '{-1, -1, -1}};
      dir_tab.push_back(d);
      d.cam = '{eye: '{-1, -1, -1}, tgt: '{1, 0, 0}, up: '{1, 1, 1}};
      dir_tab.push_back(d);
      d.cam = '{eye: '{WMAX, WMAX, WMAX}, tgt: '{WMAX, WMAX, WMAX - 1}, up: '{0, 1, 0}};
      dir_tab.push_back(d);
      d.cam = '{eye: '{ONE, -ONE, 5 * ONE}, tgt: '{0, 0, 0}, up: '{WMIN, WMAX, WMIN}};
      dir_tab.push_back(d);
      d.cam = '{eye: '{32'sh12345678, -32'sh0abcdef0, 32'sh7f00ff00},
                tgt: '{-32'sh5555aaaa, 32'sh2aaa5555, 0}, up: '{3, -2, 1}};
      dir_tab.push_back(d);
      d.cam = '{eye: '{0, 0, 0}, tgt: '{1, 1, 0}, up: '{0, 0, WMIN}};
      dir_tab.push_back(d);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[i]) send_camera(dir_tab[i].cam, dir_tab[i].typed, dir_tab[i].ent,
                                       dir_tab[i].deg);
      // pause until every row word of the table has come back
      req_valid <= 1'b0;
      wait (pending_rows.size() == 0);
      @(posedge clock);

      n = 0;
      repeat (346) begin
         c = rand_camera();
         if (n == 60) hold_left = 400;
         calm = n >= 150 && n < 210;
         send_camera(c, 0, z, 0);
         n = n + 1;
      end
      req_valid <= 1'b0;

      wait (pending_rows.size() == 0);
      repeat (LATENCY) @(posedge clock);
      if (mismatches == 0 && pending_rows.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
